/* src/salt_pkg.sv */
// Shared types and constants for the sorted address line table.
// No dependencies.
`default_nettype none
package salt_pkg;

  localparam int ADDR_W = 64;
  localparam int FILE_W = 16;
  localparam int LINE_W = 24;
  localparam int COL_W  = 16;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_LOOKUP = 2'd1,
    ACT_CLEAR  = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_CMP,
    S_SHIFT,
    S_MOVE,
    S_FETCH
  } state_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [FILE_W-1:0] file;
    logic [LINE_W-1:0] line;
    logic [COL_W-1:0]  col;
  } entry_t;

endpackage
`default_nettype wire

/* src/salt_ram.sv */
// Generic single write port RAM with registered read.
// No dependencies.
`default_nettype none
module salt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* src/sorted_address_line_table.sv */
// Sorted address-to-source line table, top level.
// Depends on salt_pkg and salt_ram.
//
// Usage: a transaction is taken when start is high and busy is low. in_action
// selects insert (0), lookup (1) or clear (2); code 3 does nothing and answers
// ok. Insert stores in_addr with file/line/column after every entry of equal or
// lower address. Lookup returns the entry with the largest address not above
// in_addr (last inserted among equals), or not_found. Each transaction yields
// one result, shown for one cycle with out_valid high; the receiver cannot
// stall it. busy stays high until the result cycle.
// Operation: entries sit in one RAM with registered read; each binary search
// probe passes through S_SEARCH and S_CMP. Lookup then reads the entry below
// the found slot in S_FETCH, or answers not_found from S_SEARCH. Insert then
// moves each entry at or above its slot up one slot through S_SHIFT and S_MOVE
// and writes the new entry in S_SHIFT. Clear, unused code and insert into a
// full table answer the cycle after start. Next transaction may start on the result cycle.
// Reset empties the table (count only, no RAM sweep) and drops any pending
// transaction.
`default_nettype none
module sorted_address_line_table
  import salt_pkg::*;
#(
  parameter int CAPACITY = 256
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [1:0]        in_action,
  input  wire logic [ADDR_W-1:0] in_addr,
  input  wire logic [FILE_W-1:0] in_file_id,
  input  wire logic [LINE_W-1:0] in_line_number,
  input  wire logic [COL_W-1:0]  in_column_number,
  output logic                   out_valid,
  output logic [1:0]             out_status,
  output logic [FILE_W-1:0]      out_found_file,
  output logic [LINE_W-1:0]      out_found_line,
  output logic [COL_W-1:0]       out_found_column
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  state_t            state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [CW-1:0]     lo_r, lo_nxt;
  logic [CW-1:0]     hi_r, hi_nxt;
  logic [CW-1:0]     mid_r, mid_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;
  logic              out_valid_r, out_valid_nxt;
  status_t           out_status_r, out_status_nxt;
  logic [FILE_W-1:0] out_file_r, out_file_nxt;
  logic [LINE_W-1:0] out_line_r, out_line_nxt;
  logic [COL_W-1:0]  out_col_r, out_col_nxt;
  action_t           act_r, act_nxt;
  entry_t            new_r, new_nxt;

  logic [CW-1:0] mid;
  logic [CW-1:0] lo_dec;
  logic [CW-1:0] idx_dec;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  entry_t        ram_wdata;
  logic [AW-1:0] ram_raddr;
  entry_t        ram_rdata;

  salt_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign mid     = lo_r + ((hi_r - lo_r) >> 1);
  assign lo_dec  = lo_r - CW'(1);
  assign idx_dec = idx_r - CW'(1);

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    mid_nxt        = mid_r;
    idx_nxt        = idx_r;
    act_nxt        = act_r;
    new_nxt        = new_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_file_nxt   = out_file_r;
    out_line_nxt   = out_line_r;
    out_col_nxt    = out_col_r;
    ram_we         = 1'b0;
    ram_waddr      = idx_r[AW-1:0];
    ram_wdata      = ram_rdata;
    ram_raddr      = mid[AW-1:0];

    case (state_r)
      S_IDLE: begin
        if (start) begin
          act_nxt      = action_t'(in_action);
          new_nxt.addr = in_addr;
          new_nxt.file = in_file_id;
          new_nxt.line = in_line_number;
          new_nxt.col  = in_column_number;
          lo_nxt       = '0;
          hi_nxt       = count_r;
          out_file_nxt = '0;
          out_line_nxt = '0;
          out_col_nxt  = '0;
          case (action_t'(in_action))
            ACT_INSERT: begin
              if (count_r == CW'(CAPACITY)) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_FULL;
              end else begin
                state_nxt = S_SEARCH;
              end
            end
            ACT_LOOKUP: begin
              state_nxt = S_SEARCH;
            end
            ACT_CLEAR: begin
              count_nxt      = '0;
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_OK;
            end
            default: begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_OK;
            end
          endcase
        end
      end
      S_SEARCH: begin
        if (lo_r < hi_r) begin
          mid_nxt   = mid;
          state_nxt = S_CMP;
        end else if (act_r == ACT_INSERT) begin
          idx_nxt   = count_r;
          state_nxt = S_SHIFT;
        end else if (lo_r == '0) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_NOT_FOUND;
          state_nxt      = S_IDLE;
        end else begin
          ram_raddr = lo_dec[AW-1:0];
          state_nxt = S_FETCH;
        end
      end
      S_CMP: begin
        if (ram_rdata.addr <= new_r.addr) begin
          lo_nxt = mid_r + CW'(1);
        end else begin
          hi_nxt = mid_r;
        end
        state_nxt = S_SEARCH;
      end
      S_SHIFT: begin
        if (idx_r > lo_r) begin
          ram_raddr = idx_dec[AW-1:0];
          state_nxt = S_MOVE;
        end else begin
          ram_we         = 1'b1;
          ram_waddr      = lo_r[AW-1:0];
          ram_wdata      = new_r;
          count_nxt      = count_r + CW'(1);
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          state_nxt      = S_IDLE;
        end
      end
      S_MOVE: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r[AW-1:0];
        ram_wdata = ram_rdata;
        idx_nxt   = idx_dec;
        state_nxt = S_SHIFT;
      end
      S_FETCH: begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = ST_OK;
        out_file_nxt   = ram_rdata.file;
        out_line_nxt   = ram_rdata.line;
        out_col_nxt    = ram_rdata.col;
        state_nxt      = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    mid_r        <= mid_nxt;
    idx_r        <= idx_nxt;
    act_r        <= act_nxt;
    new_r        <= new_nxt;
    out_status_r <= out_status_nxt;
    out_file_r   <= out_file_nxt;
    out_line_r   <= out_line_nxt;
    out_col_r    <= out_col_nxt;
  end

  assign busy             = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_found_file   = out_file_r;
  assign out_found_line   = out_line_r;
  assign out_found_column = out_col_r;

endmodule
`default_nettype wire
